/* src/sawbc_pkg.sv */
package sawbc_pkg;

  // Geometry defaults; all three must be powers of two
  localparam int unsigned DEF_NUM_SETS    = 8;
  localparam int unsigned DEF_NUM_WAYS    = 4;
  localparam int unsigned DEF_BLOCK_BYTES = 32;

  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned LAT_W     = 9;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned REG_W     = 8;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned OUT_PAD_W = 5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CACHE_ENABLE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LOOKUP_LATENCY = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_READ_LATENCY   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_LATENCY  = CFG_IDX_W'(3);

  // Register reset values
  localparam logic [REG_W-1:0] RST_LOOKUP_LATENCY = REG_W'(1);
  localparam logic [REG_W-1:0] RST_READ_LATENCY   = REG_W'(30);
  localparam logic [REG_W-1:0] RST_WRITE_LATENCY  = REG_W'(30);

  // Access kinds carried in the input tuser
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_STORE = 1'b1;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Access counters, packed so that load sits lowest in the result word
  typedef struct packed {
    logic [CNT_W-1:0] writeback;
    logic [CNT_W-1:0] store_miss;
    logic [CNT_W-1:0] load_miss;
    logic [CNT_W-1:0] store;
    logic [CNT_W-1:0] load;
  } counters_t;

endpackage

/* src/set_assoc_writeback_cache_tags.sv */
// Channel    | Direction | Handshake                    | Payload
// -----------+-----------+------------------------------+------------------------------------
// s_axis     | in        | s_axis_tvalid / s_axis_tready | tdata: address; tuser: opcode
// m_axis     | out       | m_axis_tvalid / m_axis_tready | tdata: hit, wrote_back, latency,
//            |           |                              |   five saturating access counters
// cfg        | in        | cfg_valid_i / cfg_ready_o    | cfg_index_i, cfg_data_i
//
// One word per cycle is sustained while m_axis is not stalled; a taken word passes the input
// register and then the result register before it appears on m_axis. Between the two sits the
// single lookup-and-update pass over the flop tag array.
// Reset clears valid and dirty bits, victim pointers and counters at once: no clearing pass.
// A stalled output holds the result register and the input register, which then holds s_axis.
// The configuration channel is always ready and takes effect on the next word processed.
module set_assoc_writeback_cache_tags
  import sawbc_pkg::*;
#(
  parameter int unsigned NUM_SETS    = DEF_NUM_SETS,
  parameter int unsigned NUM_WAYS    = DEF_NUM_WAYS,
  parameter int unsigned BLOCK_BYTES = DEF_BLOCK_BYTES
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [ADDR_W-1:0]    s_axis_tdata,   // [31:0] address
  input  logic                 s_axis_tuser,   // [0] opcode (0 load, 1 store)

  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [0] hit, [1] wrote_back, [10:2] latency, [42:11] load_total, [74:43] store_total,
  // [106:75] load_miss_total, [138:107] store_miss_total, [170:139] writeback_total,
  // [175:171] zero
  output logic [OUT_PAD_W+5*CNT_W+LAT_W+1:0] m_axis_tdata,

  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [REG_W-1:0]     cfg_data_i
);

  // Address split: offset bits, index bits, then the tag
  localparam int unsigned OFF_B = $clog2(BLOCK_BYTES);
  localparam int unsigned IDX_B = $clog2(NUM_SETS);
  localparam int unsigned TAG_W = ADDR_W - OFF_B - IDX_B;
  localparam int unsigned SET_W = (IDX_B > 0) ? IDX_B : 1;
  localparam int unsigned WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

  // Configuration registers
  logic             enable_q;
  logic [REG_W-1:0] lookup_lat_q;
  logic [REG_W-1:0] read_lat_q;
  logic [REG_W-1:0] write_lat_q;

  // Input register
  logic              in_valid_q;
  logic [ADDR_W-1:0] in_addr_q;
  logic              in_op_q;

  // Tag array and per-line state, all in flops
  logic [TAG_W-1:0]    tag_q   [NUM_WAYS][NUM_SETS];
  logic [NUM_WAYS-1:0] valid_q [NUM_SETS];
  logic [NUM_WAYS-1:0] dirty_q [NUM_SETS];
  logic [WAY_W-1:0]    vptr_q  [NUM_SETS];

  // Result register; the counters double as the reported totals
  logic             out_valid_q;
  logic             out_hit_q;
  logic             out_wb_q;
  logic [LAT_W-1:0] out_lat_q;
  counters_t        cnt_q, cnt_d;

  logic                proc;
  logic [SET_W-1:0]    set_idx;
  logic [TAG_W-1:0]    tag;
  logic [NUM_WAYS-1:0] match;
  logic [NUM_WAYS-1:0] pick_oh;
  logic [WAY_W-1:0]    hit_way;
  logic [WAY_W-1:0]    victim;
  logic [WAY_W-1:0]    victim_next;
  logic                hit;
  logic                victim_dirty;
  logic                is_store;
  logic [LAT_W-1:0]    lat;

  // Process the held word whenever the result register is free or being drained
  assign proc          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || proc;
  assign cfg_ready_o   = 1'b1;
  assign is_store      = (in_op_q == OP_STORE);

  // Index and tag of the held address
  assign set_idx = SET_W'((in_addr_q >> OFF_B) & ADDR_W'(NUM_SETS - 1));
  assign tag     = TAG_W'(in_addr_q >> (OFF_B + IDX_B));

  // Compare every way of the set at once; the lowest matching way wins
  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      match[w] = valid_q[set_idx][w] && (tag_q[w][set_idx] == tag);
    end
  end

  assign pick_oh = match & (~match + NUM_WAYS'(1));
  assign hit     = |match;

  always_comb begin
    hit_way = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (pick_oh[w]) begin
        hit_way = hit_way | WAY_W'(w);
      end
    end
  end

  // Round-robin victim and its successor
  assign victim       = vptr_q[set_idx];
  assign victim_dirty = dirty_q[set_idx][victim];
  assign victim_next  = (victim == WAY_W'(NUM_WAYS - 1)) ? '0 : victim + WAY_W'(1);

  // Stall cycles: fixed latency when bypassed, lookup on a hit, fill on a miss plus writeback if the victim is dirty
  always_comb begin
    if (!enable_q) begin
      lat = is_store ? LAT_W'(write_lat_q) : LAT_W'(read_lat_q);
    end else if (hit) begin
      lat = LAT_W'(lookup_lat_q);
    end else if (victim_dirty) begin
      lat = LAT_W'(read_lat_q) + LAT_W'(write_lat_q);
    end else begin
      lat = LAT_W'(read_lat_q);
    end
  end

  // Saturating counter updates; bypassed words leave them alone
  always_comb begin
    cnt_d = cnt_q;
    if (proc && enable_q) begin
      if (is_store) begin
        if (cnt_q.store != CNT_MAX) cnt_d.store = cnt_q.store + CNT_W'(1);
      end else begin
        if (cnt_q.load != CNT_MAX) cnt_d.load = cnt_q.load + CNT_W'(1);
      end
      if (!hit) begin
        if (is_store) begin
          if (cnt_q.store_miss != CNT_MAX) cnt_d.store_miss = cnt_q.store_miss + CNT_W'(1);
        end else begin
          if (cnt_q.load_miss != CNT_MAX) cnt_d.load_miss = cnt_q.load_miss + CNT_W'(1);
        end
        if (victim_dirty && (cnt_q.writeback != CNT_MAX)) begin
          cnt_d.writeback = cnt_q.writeback + CNT_W'(1);
        end
      end
    end
  end

  // Configuration writes; unknown indexes drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= 1'b1;
      lookup_lat_q <= RST_LOOKUP_LATENCY;
      read_lat_q   <= RST_READ_LATENCY;
      write_lat_q  <= RST_WRITE_LATENCY;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_CACHE_ENABLE:   enable_q     <= cfg_data_i[0];
        REG_LOOKUP_LATENCY: lookup_lat_q <= cfg_data_i;
        REG_READ_LATENCY:   read_lat_q   <= cfg_data_i;
        REG_WRITE_LATENCY:  write_lat_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // Input register payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_addr_q <= s_axis_tdata;
      in_op_q   <= s_axis_tuser;
    end
  end

  // Line state: mark dirty on a store hit, refill the victim on a miss
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_SETS; s++) begin
        valid_q[s] <= '0;
        dirty_q[s] <= '0;
        vptr_q[s]  <= '0;
      end
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (proc && enable_q) begin
        if (hit) begin
          if (is_store) dirty_q[set_idx][hit_way] <= 1'b1;
        end else begin
          valid_q[set_idx][victim] <= 1'b1;
          dirty_q[set_idx][victim] <= is_store;
          vptr_q[set_idx]          <= victim_next;
        end
      end
    end
  end

  // Tags need no reset: a tag is only read behind its valid bit
  always_ff @(posedge clk_i) begin
    if (proc && enable_q && !hit) begin
      tag_q[victim][set_idx] <= tag;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      out_hit_q <= enable_q && hit;
      out_wb_q  <= enable_q && !hit && victim_dirty;
      out_lat_q <= lat;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {OUT_PAD_W'(0), cnt_q, out_lat_q, out_wb_q, out_hit_q};

  // A cached hit resolves to exactly one way
  a_hit_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && enable_q && hit |-> $onehot(pick_oh))
    else $error("hit without a single selected way");

  // A cached miss leaves the refilled way valid
  a_refill_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && enable_q && !hit |=> valid_q[$past(set_idx)][$past(victim)])
    else $error("refilled way not valid");

  // The load and writeback counters saturate and never wrap
  a_cnt_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 (cnt_q.load >= $past(cnt_q.load)) && (cnt_q.writeback >= $past(cnt_q.writeback)))
    else $error("counter went backwards");

  // A bypassed word changes no counter
  a_bypass_still: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && !enable_q |=> $stable(cnt_q))
    else $error("bypassed word touched the counters");

  // A writeback only ever goes with a miss
  a_wb_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_wb_q |-> !out_hit_q)
    else $error("writeback reported on a hit");

endmodule

/* tb/sv/testbench.sv */
module testbench
  import sawbc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Address split for the default geometry: offset below, set index above it, tag on top
  localparam int unsigned OFFSET_W = $clog2(DEF_BLOCK_BYTES);
  localparam int unsigned SET_W    = $clog2(DEF_NUM_SETS);
  localparam int unsigned TAG_W    = ADDR_W - OFFSET_W - SET_W;
  localparam int unsigned WAY_W    = $clog2(DEF_NUM_WAYS);

  // Register indexes that decode to nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = '1;

  localparam int unsigned TAG_POOL_SIZE = 6;
  localparam int unsigned PHASE_WORDS   = 283;
  localparam int          CYCLE_LIMIT   = 200000;

  // One result word as the block packs it, hit in the lowest bit
  typedef struct packed {
    counters_t              cnt;
    logic [LAT_W-1:0]       latency;
    logic                   wrote_back;
    logic                   hit;
  } access_result_t;

  localparam int unsigned RESULT_W = $bits(access_result_t);

  logic                              clk_i         = 1'b0;
  logic                              rst_ni        = 1'b0;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [ADDR_W-1:0]                 s_axis_tdata  = '0;
  logic                              s_axis_tuser  = OP_LOAD;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [OUT_PAD_W+5*CNT_W+LAT_W+1:0] m_axis_tdata;
  logic                              cfg_valid_i   = 1'b0;
  logic                              cfg_ready_o;
  logic [CFG_IDX_W-1:0]              cfg_index_i   = '0;
  logic [REG_W-1:0]                  cfg_data_i    = '0;

  set_assoc_writeback_cache_tags i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------------------
  // Shadow copy of the tag side: tags, valid and dirty bits, victim pointers, counters,
  // and the four registers as the block should hold them.
  // ---------------------------------------------------------------------------------------
  logic [TAG_W-1:0]  shadow_tag   [DEF_NUM_SETS][DEF_NUM_WAYS];
  logic              shadow_valid [DEF_NUM_SETS][DEF_NUM_WAYS];
  logic              shadow_dirty [DEF_NUM_SETS][DEF_NUM_WAYS];
  logic [WAY_W-1:0]  shadow_victim[DEF_NUM_SETS];
  counters_t         shadow_cnt;

  logic              reg_enable;
  logic [REG_W-1:0]  reg_lookup_lat;
  logic [REG_W-1:0]  reg_read_lat;
  logic [REG_W-1:0]  reg_write_lat;

  access_result_t    pending_results[$];
  logic [TAG_W-1:0]  tag_pool[TAG_POOL_SIZE];

  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;
  int words_checked  = 0;
  int hit_words      = 0;
  int writeback_words = 0;
  int bypass_words   = 0;
  int reg_writes     = 0;

  function automatic logic [CNT_W-1:0] saturating_inc(input logic [CNT_W-1:0] value);
    return (value == CNT_MAX) ? value : value + 1'b1;
  endfunction

  // Look one access up in the shadow cache, update it, and return the word it should give
  function automatic access_result_t cache_access(input logic [ADDR_W-1:0] addr,
                                                  input logic op);
    access_result_t   res;
    logic [SET_W-1:0] set_idx;
    logic [TAG_W-1:0] tag;
    logic [WAY_W-1:0] vic;
    int               way;
    res      = '0;
    set_idx  = addr[OFFSET_W +: SET_W];
    tag      = addr[ADDR_W-1 -: TAG_W];
    way      = -1;
    if (!reg_enable) begin
      // Bypass: fixed latency by kind, counters reported as they stand
      res.latency = (op == OP_STORE) ? LAT_W'(reg_write_lat) : LAT_W'(reg_read_lat);
      res.cnt     = shadow_cnt;
      bypass_words++;
      return res;
    end
    if (op == OP_STORE) shadow_cnt.store = saturating_inc(shadow_cnt.store);
    else                shadow_cnt.load  = saturating_inc(shadow_cnt.load);
    // Lowest valid way with the tag wins; an invalid way with a stale tag never hits
    for (int w = DEF_NUM_WAYS - 1; w >= 0; w--) begin
      if (shadow_valid[set_idx][w] && shadow_tag[set_idx][w] == tag) way = w;
    end
    if (way >= 0) begin
      res.hit = 1'b1;
      if (op == OP_STORE) shadow_dirty[set_idx][way] = 1'b1;
      res.latency = LAT_W'(reg_lookup_lat);
      hit_words++;
    end else begin
      vic         = shadow_victim[set_idx];
      res.latency = LAT_W'(reg_read_lat);
      if (shadow_dirty[set_idx][vic]) begin
        res.wrote_back       = 1'b1;
        res.latency          = res.latency + LAT_W'(reg_write_lat);
        shadow_cnt.writeback = saturating_inc(shadow_cnt.writeback);
        writeback_words++;
      end
      shadow_dirty[set_idx][vic] = (op == OP_STORE);
      shadow_valid[set_idx][vic] = 1'b1;
      shadow_tag[set_idx][vic]   = tag;
      shadow_victim[set_idx]     = vic + 1'b1;
      if (op == OP_STORE) shadow_cnt.store_miss = saturating_inc(shadow_cnt.store_miss);
      else                shadow_cnt.load_miss  = saturating_inc(shadow_cnt.load_miss);
    end
    res.cnt = shadow_cnt;
    return res;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Driving: everything changes on the falling edge, handshakes are judged on the rising one.
  // ---------------------------------------------------------------------------------------

  // Offer one access word, idling first at the current rate, and record its expected result
  task automatic send_access(input logic [ADDR_W-1:0] addr, input logic op);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= addr;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(cache_access(addr, op));
  endtask

  // Hold the input side idle until every outstanding result word has come back
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Write one register; only called with the block idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    reg_writes++;
    case (idx)
      REG_CACHE_ENABLE:   reg_enable     = data[0];
      REG_LOOKUP_LATENCY: reg_lookup_lat = data;
      REG_READ_LATENCY:   reg_read_lat   = data;
      REG_WRITE_LATENCY:  reg_write_lat  = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_latencies(input logic [REG_W-1:0] lookup, input logic [REG_W-1:0] rd,
                               input logic [REG_W-1:0] wr);
    write_reg(REG_LOOKUP_LATENCY, lookup);
    write_reg(REG_READ_LATENCY, rd);
    write_reg(REG_WRITE_LATENCY, wr);
  endtask

  // Mostly addresses from a small tag pool so that sets fill, hit and evict; some pure noise
  function automatic logic [ADDR_W-1:0] pick_address();
    if ($urandom_range(99) < 12) return $urandom();
    return {tag_pool[$urandom_range(TAG_POOL_SIZE-1)], SET_W'($urandom_range(DEF_NUM_SETS-1)),
            OFFSET_W'($urandom_range(DEF_BLOCK_BYTES-1))};
  endfunction

  // ---------------------------------------------------------------------------------------
  // Result side: random back-pressure, and every accepted word checked field by field.
  // ---------------------------------------------------------------------------------------
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic void compare_field(input string name, input logic [CNT_W-1:0] want,
                                        input logic [CNT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    access_result_t got;
    access_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = access_result_t'(m_axis_tdata[RESULT_W-1:0]);
      if (pending_results.size() == 0) begin
        $error("result word 0x%0h with no access outstanding", m_axis_tdata);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        words_checked++;
        compare_field("hit",              CNT_W'(want.hit),        CNT_W'(got.hit));
        compare_field("wrote_back",       CNT_W'(want.wrote_back), CNT_W'(got.wrote_back));
        compare_field("latency",          CNT_W'(want.latency),    CNT_W'(got.latency));
        compare_field("load_total",       want.cnt.load,           got.cnt.load);
        compare_field("store_total",      want.cnt.store,          got.cnt.store);
        compare_field("load_miss_total",  want.cnt.load_miss,      got.cnt.load_miss);
        compare_field("store_miss_total", want.cnt.store_miss,     got.cnt.store_miss);
        compare_field("writeback_total",  want.cnt.writeback,      got.cnt.writeback);
      end
    end
  end

  // Watchdog: give up well past the slowest legal run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("set_assoc_writeback_cache_tags: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // Fill, hit, dirty and evict set 0 and set 7 by hand; field extremes; the widest latency
  task automatic test_fill_and_evict();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_access(32'h0000_0000, OP_LOAD);   // invalid way holding a zero tag must miss
    send_access(32'h0000_0000, OP_LOAD);   // now a hit
    send_access(32'h0000_001F, OP_STORE);  // store hit dirties way 0
    send_access(32'hFFFF_FFFF, OP_STORE);  // top set, all-ones tag
    send_access(32'hFFFF_FFE0, OP_LOAD);
    send_access(32'h0000_0100, OP_LOAD);
    send_access(32'h0000_0200, OP_STORE);
    send_access(32'h0000_0300, OP_LOAD);   // set 0 now full
    send_access(32'h0000_0400, OP_LOAD);   // evicts dirty way 0
    send_access(32'h0000_0100, OP_LOAD);   // survivor still hits
    send_access(32'h0000_0500, OP_LOAD);   // clean victim
    send_access(32'h0000_0600, OP_LOAD);   // dirty victim
    send_access(32'h0000_0000, OP_STORE);  // evicted tag misses again
    send_access(32'hAAAA_AA55, OP_LOAD);
    send_access(32'h5555_55AA, OP_STORE);
    drain_results();
    // Extremes: free hits, slowest fill and write-back, so a dirty miss costs 510
    set_latencies(8'h00, 8'hFF, 8'hFF);
    send_access(32'h0000_0700, OP_STORE);
    send_access(32'h0000_0000, OP_LOAD);
    send_access(32'h0000_0800, OP_STORE);
    send_access(32'h0000_0900, OP_LOAD);
    send_access(32'h0000_0A00, OP_LOAD);
    drain_results();
  endtask

  // Bypass mode, an over-wide register value and writes to unused indexes
  task automatic test_bypass_and_registers();
    send_idle_pct = 25;
    recv_idle_pct = 72;
    write_reg(REG_CACHE_ENABLE, 8'hFE);    // only bit 0 counts: cache off
    write_reg(REG_UNUSED_FIRST, 8'h5A);
    write_reg(REG_UNUSED_LAST, 8'hA5);
    send_access(32'h0000_0A00, OP_LOAD);
    send_access(32'hFFFF_FFFF, OP_STORE);
    send_access(32'h1234_5678, OP_STORE);
    drain_results();
    write_reg(REG_CACHE_ENABLE, 8'h01);
    set_latencies(8'h07, 8'h13, 8'h21);
    send_access(32'h0000_0A00, OP_LOAD);   // bypass left the tags alone: still a hit
    send_access(32'h0000_0A00, OP_STORE);
    drain_results();
  endtask

  // Random traffic at one idling mix, with a full pause and a register change half-way
  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input logic [REG_W-1:0] lookup,
                                     input logic [REG_W-1:0] rd,
                                     input logic [REG_W-1:0] wr);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    foreach (tag_pool[i]) tag_pool[i] = TAG_W'($urandom());
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    set_latencies(lookup, rd, wr);
    for (int n = 0; n < PHASE_WORDS; n++) begin
      if (n == PHASE_WORDS / 2) begin
        // Hold the sender until the pipe is empty, then move the latencies somewhere new
        drain_results();
        set_latencies(REG_W'($urandom()), REG_W'($urandom()), REG_W'($urandom()));
        send_idle_pct = ($urandom_range(3) == 0) ? 0 : send_pct;
      end
      send_access(pick_address(), $urandom_range(1) ? OP_STORE : OP_LOAD);
    end
    drain_results();
  endtask

  // ---------------------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------------------
  initial begin
    // Mirror the reset state
    foreach (shadow_tag[s, w]) begin
      shadow_tag[s][w]   = '0;
      shadow_valid[s][w] = 1'b0;
      shadow_dirty[s][w] = 1'b0;
    end
    foreach (shadow_victim[s]) shadow_victim[s] = '0;
    shadow_cnt     = '0;
    reg_enable     = 1'b1;
    reg_lookup_lat = RST_LOOKUP_LATENCY;
    reg_read_lat   = RST_READ_LATENCY;
    reg_write_lat  = RST_WRITE_LATENCY;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_fill_and_evict();
    test_bypass_and_registers();
    test_random_traffic(25, 72, 8'h00, 8'hFF, 8'hFF);
    test_random_traffic(72, 25, 8'hFF, 8'h00, 8'h00);
    test_random_traffic(0, 0, RST_LOOKUP_LATENCY, RST_READ_LATENCY, RST_WRITE_LATENCY);

    // Let any stray word surface before the verdict
    repeat (8) @(posedge clk_i);
    $display("Checked %0d result words: %0d hits, %0d dirty evictions, %0d bypassed.",
             words_checked, hit_words, writeback_words, bypass_words);
    $display("Made %0d register writes over three idling mixes.", reg_writes);
    if (mismatch_count == 0) begin
      $display("set_assoc_writeback_cache_tags: match");
    end else begin
      $display("set_assoc_writeback_cache_tags: mismatch");
    end
    $finish;
  end

endmodule
